### sv/dns_query_hijack_responder_defines.svh
// Assertion macros shared by the DNS responder modules.
`ifndef DNS_QUERY_HIJACK_RESPONDER_DEFINES_SVH
`define DNS_QUERY_HIJACK_RESPONDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DQHR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dqhr assertion failed");
`define DQHR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqhr assertion failed");
`else
`define DQHR_ASSERT(lbl, clk, rst_n, prop)
`define DQHR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/dqhr_pkg.sv
// Types, constants and helper functions of the DNS responder.
package dqhr_pkg;

    localparam int unsigned MAX_QUERY_LEN_DEF = 512;
    localparam int unsigned POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
    localparam logic [POS_W-1:0] NAME_START = 10'd12;
    localparam logic [POS_W-1:0] HDR_LAST = 10'd11;

    localparam int unsigned CAP_W = 10;
    localparam logic [CAP_W-1:0] CAP_RESET = 10'd528;
    localparam logic [31:0] ANSWER_RESET = 32'd0;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_CAPACITY = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    localparam int unsigned ANS_LEN = 16;
    localparam int unsigned STEP_W = 5;
    localparam logic [10:0] ANS_ROOM = 11'd17;

    localparam logic [7:0] FLAGS_HI = 8'h81;
    localparam logic [7:0] FLAGS_LO = 8'h80;
    localparam logic [15:0] TYPE_A = 16'd1;
    localparam logic [15:0] TYPE_ANY = 16'd255;
    localparam logic [15:0] CLASS_IN = 16'd1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_NAME,
        PH_FIELDS,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_ANSWER,
        TAIL_DISCARD
    } t_tail;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        t_tail      tail;
    } t_cmd;

    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] addr);
        logic [7:0] v;
        case (idx)
            4'd0: v = 8'hC0;
            4'd1: v = 8'h0C;
            4'd3: v = 8'h01;
            4'd5: v = 8'h01;
            4'd11: v = 8'h04;
            4'd12: v = addr[31:24];
            4'd13: v = addr[23:16];
            4'd14: v = addr[15:8];
            4'd15: v = addr[7:0];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### sv/dqhr_if.sv
// Request channel interfaces for query bytes and reply bytes.
interface dqhr_query_if;
    logic       valid;
    logic       ready;
    logic [7:0] query_byte;
    logic       last_byte;

    modport source (output valid, output query_byte, output last_byte, input ready);
    modport sink (input valid, input query_byte, input last_byte, output ready);
endinterface

interface dqhr_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_end;
    logic       reply_keep;

    modport source (output valid, output reply_byte, output reply_end,
                    output reply_keep, input ready);
    modport sink (input valid, input reply_byte, input reply_end,
                  input reply_keep, output ready);
endinterface

### sv/dqhr_front.sv
// Front end: parses query bytes and issues emit commands to the queue.
`include "dns_query_hijack_responder_defines.svh"

module dqhr_front #(
    parameter int unsigned MAX_QUERY_LEN = dqhr_pkg::MAX_QUERY_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dqhr_query_if.sink                    i_query,
    input  logic [dqhr_pkg::CAP_W-1:0]    i_capacity,
    input  logic                          i_full,
    output logic                          o_push,
    output dqhr_pkg::t_cmd                o_cmd
);

    localparam logic [dqhr_pkg::POS_W:0] MAX_L = (dqhr_pkg::POS_W + 1)'(MAX_QUERY_LEN);

    logic [dqhr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [dqhr_pkg::POS_W-1:0] r_lab_end, n_lab_end;
    dqhr_pkg::t_phase           r_phase, n_phase, c_phase;
    logic                       r_rej, n_rej, c_rej;
    logic [15:0]                r_qtype, n_qtype;
    logic [15:0]                r_qclass, n_qclass;

    logic                       acc;
    logic [7:0]                 b;
    logic [dqhr_pkg::POS_W:0]   pos_x;
    logic [dqhr_pkg::POS_W:0]   nxt;
    logic [1:0]                 off;
    logic                       emit;
    logic [7:0]                 ob;

    assign i_query.ready = !i_full;
    assign acc = i_query.valid && !i_full;
    assign b = i_query.query_byte;
    assign pos_x = {1'b0, r_pos};
    assign nxt = pos_x + {3'b000, b} + 11'd1;
    assign off = 2'(r_pos - r_lab_end);

    always_comb begin
        c_phase = r_phase;
        c_rej = r_rej;
        n_lab_end = r_lab_end;
        n_qtype = r_qtype;
        n_qclass = r_qclass;
        n_pos = r_pos;
        if (acc && !r_rej) begin
            if (pos_x >= MAX_L) begin
                c_rej = 1'b1;
            end else begin
                unique case (r_phase)
                    dqhr_pkg::PH_HEADER: begin
                        if (r_pos == 10'd2 && (b[7] || b[6:3] != 4'd0)) begin
                            c_rej = 1'b1;
                        end
                        if (r_pos == 10'd4 && b != 8'd0) begin
                            c_rej = 1'b1;
                        end
                        if (r_pos == 10'd5 && b != 8'd1) begin
                            c_rej = 1'b1;
                        end
                        if (r_pos == dqhr_pkg::HDR_LAST) begin
                            c_phase = dqhr_pkg::PH_NAME;
                            n_lab_end = dqhr_pkg::NAME_START;
                        end
                    end
                    dqhr_pkg::PH_NAME: begin
                        if (r_pos == r_lab_end) begin
                            if (b == 8'd0) begin
                                c_phase = dqhr_pkg::PH_FIELDS;
                                n_lab_end = r_pos + 10'd1;
                            end else if (b[7:6] != 2'b00) begin
                                c_rej = 1'b1;
                            end else if (nxt >= MAX_L) begin
                                c_rej = 1'b1;
                            end else begin
                                n_lab_end = nxt[dqhr_pkg::POS_W-1:0];
                            end
                        end
                    end
                    dqhr_pkg::PH_FIELDS: begin
                        if (!off[1]) begin
                            n_qtype = {r_qtype[7:0], b};
                        end else begin
                            n_qclass = {r_qclass[7:0], b};
                        end
                        if (off == 2'd3) begin
                            if ((r_qtype == dqhr_pkg::TYPE_A || r_qtype == dqhr_pkg::TYPE_ANY)
                                && {r_qclass[7:0], b} == dqhr_pkg::CLASS_IN
                                && pos_x + dqhr_pkg::ANS_ROOM <= {1'b0, i_capacity}) begin
                                c_phase = dqhr_pkg::PH_DONE;
                            end else begin
                                c_rej = 1'b1;
                            end
                        end
                    end
                    dqhr_pkg::PH_DONE: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (acc && r_pos != dqhr_pkg::POS_MAX) begin
            n_pos = r_pos + 10'd1;
        end
        n_phase = c_phase;
        n_rej = c_rej;
        if (acc && i_query.last_byte) begin
            n_pos = '0;
            n_lab_end = '0;
            n_phase = dqhr_pkg::PH_HEADER;
            n_rej = 1'b0;
            n_qtype = '0;
            n_qclass = '0;
        end
    end

    always_comb begin
        emit = !c_rej && r_phase != dqhr_pkg::PH_DONE;
        ob = b;
        if (r_phase == dqhr_pkg::PH_HEADER) begin
            case (r_pos)
                10'd2: ob = dqhr_pkg::FLAGS_HI;
                10'd3: ob = dqhr_pkg::FLAGS_LO;
                10'd6: ob = 8'h00;
                10'd7: ob = 8'h01;
                10'd8, 10'd9, 10'd10, 10'd11: ob = 8'h00;
                default: ob = b;
            endcase
        end
        o_push = acc && (emit || i_query.last_byte);
        o_cmd.emit = emit;
        o_cmd.data = ob;
        if (!i_query.last_byte) begin
            o_cmd.tail = dqhr_pkg::TAIL_NONE;
        end else if (!c_rej && c_phase == dqhr_pkg::PH_DONE) begin
            o_cmd.tail = dqhr_pkg::TAIL_ANSWER;
        end else begin
            o_cmd.tail = dqhr_pkg::TAIL_DISCARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_lab_end <= '0;
            r_phase <= dqhr_pkg::PH_HEADER;
            r_rej <= 1'b0;
            r_qtype <= '0;
            r_qclass <= '0;
        end else begin
            r_pos <= n_pos;
            r_lab_end <= n_lab_end;
            r_phase <= n_phase;
            r_rej <= n_rej;
            r_qtype <= n_qtype;
            r_qclass <= n_qclass;
        end
    end

    `DQHR_ASSERT(a_fields_after_name, i_clk, i_rst_n, (r_phase == dqhr_pkg::PH_FIELDS) |-> (r_lab_end <= r_pos))
    `DQHR_ASSERT(a_rejected_silent, i_clk, i_rst_n, (r_rej && !i_query.last_byte) |-> !o_push)

endmodule

### sv/dqhr_queue.sv
// Short command queue between the parser and the reply emitter.
`include "dns_query_hijack_responder_defines.svh"

module dqhr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dqhr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output dqhr_pkg::t_cmd o_cmd
);

    dqhr_pkg::t_cmd                r_mem [dqhr_pkg::QUEUE_DEPTH];
    logic [dqhr_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [dqhr_pkg::QCNT_W-1:0]   r_cnt;

    assign o_full = r_cnt == dqhr_pkg::QCNT_W'(dqhr_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `DQHR_ASSERT(a_count_bound, i_clk, i_rst_n, r_cnt <= dqhr_pkg::QCNT_W'(dqhr_pkg::QUEUE_DEPTH))
    `DQHR_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> o_valid)

endmodule

### sv/dqhr_back.sv
// Back end: turns queued commands into reply bytes and appends the answer or a closing zero byte.
`include "dns_query_hijack_responder_defines.svh"

module dqhr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dqhr_pkg::t_cmd i_cmd,
    input  logic [31:0]    i_address,
    output logic           o_pop,
    dqhr_reply_if.source   o_reply
);

    logic [dqhr_pkg::STEP_W-1:0] r_step, n_step;
    logic [dqhr_pkg::STEP_W-1:0] e;
    logic [3:0]                  e_m1;
    logic                        r_valid;
    logic [7:0]                  r_byte;
    logic                        r_end, r_keep;
    logic [7:0]                  res_byte;
    logic                        res_end, res_keep, done;
    logic                        advance;

    assign e = (r_step == '0 && !i_cmd.emit) ? 5'd1 : r_step;
    assign e_m1 = e[3:0] - 4'd1;
    assign advance = i_valid && (!r_valid || o_reply.ready);

    always_comb begin
        if (e == '0) begin
            res_byte = i_cmd.data;
            res_end = 1'b0;
            res_keep = 1'b0;
            done = i_cmd.tail == dqhr_pkg::TAIL_NONE;
        end else if (i_cmd.tail == dqhr_pkg::TAIL_DISCARD) begin
            res_byte = 8'h00;
            res_end = 1'b1;
            res_keep = 1'b0;
            done = 1'b1;
        end else begin
            res_byte = dqhr_pkg::answer_byte(e_m1, i_address);
            res_end = e == dqhr_pkg::STEP_W'(dqhr_pkg::ANS_LEN);
            res_keep = res_end;
            done = res_end;
        end
        o_pop = advance && done;
        n_step = r_step;
        if (advance) begin
            n_step = done ? '0 : e + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (o_reply.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= res_byte;
            r_end <= res_end;
            r_keep <= res_keep;
        end
    end

    assign o_reply.valid = r_valid;
    assign o_reply.reply_byte = r_byte;
    assign o_reply.reply_end = r_end;
    assign o_reply.reply_keep = r_keep;

    `DQHR_ASSERT(a_step_bound, i_clk, i_rst_n, r_step <= dqhr_pkg::STEP_W'(dqhr_pkg::ANS_LEN))
    `DQHR_ASSERT_NEXT(a_pop_clears_step, i_clk, i_rst_n, o_pop, r_step == '0)

endmodule

### sv/dns_query_hijack_responder.sv
// Top level of the captive portal DNS A record responder.
// Query bytes enter on i_query, one request per byte, with last_byte on the
// final byte of a packet. Reply bytes leave on o_reply, one request each.
// A byte is accepted every cycle while the four-entry command queue has room.
// An echoed byte passes from the command queue through the output register
// to o_reply. The final byte of an accepted packet adds sixteen answer bytes,
// one per cycle from the emitter while the receiver is ready, with reply_end
// and reply_keep set on the last; a rejected packet ends with one zero byte
// carrying reply_end. While the emitter appends an answer it pops no
// command, so the queue fills if bytes keep arriving and i_query.ready drops.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and input is held off; nothing is dropped.
// Configuration writes on i_cfg_we must be made only while no packet is in
// flight; the block does not enforce this. Reset clears the parser, the queue
// and the output, sets the answer address to zero and the capacity to 528.
module dns_query_hijack_responder #(
    parameter int unsigned MAX_QUERY_LEN = dqhr_pkg::MAX_QUERY_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dqhr_query_if.sink                        i_query,
    dqhr_reply_if.source                      o_reply,
    input  logic                              i_cfg_we,
    input  logic [dqhr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic [31:0]                r_address;
    logic [dqhr_pkg::CAP_W-1:0] r_capacity;
    logic                       push, pop, full, head_valid;
    dqhr_pkg::t_cmd             push_cmd, head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= dqhr_pkg::ANSWER_RESET;
            r_capacity <= dqhr_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dqhr_pkg::CFG_ANSWER_ADDRESS) begin
                r_address <= i_cfg_data;
            end
            if (i_cfg_index == dqhr_pkg::CFG_REPLY_CAPACITY) begin
                r_capacity <= i_cfg_data[dqhr_pkg::CAP_W-1:0];
            end
        end
    end

    dqhr_front #(
        .MAX_QUERY_LEN(MAX_QUERY_LEN)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_query(i_query),
        .i_capacity(r_capacity),
        .i_full(full),
        .o_push(push),
        .o_cmd(push_cmd)
    );

    dqhr_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_cmd(push_cmd),
        .i_pop(pop),
        .o_full(full),
        .o_valid(head_valid),
        .o_cmd(head_cmd)
    );

    dqhr_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(head_valid),
        .i_cmd(head_cmd),
        .i_address(r_address),
        .o_pop(pop),
        .o_reply(o_reply)
    );

endmodule
